[rtl/olal_pkg.sv]
// olal_pkg: shared types and constants for the ordered list block
// used by olal_front, olal_back and ordered_list_append_remove; no dependencies
package olal_pkg;

   localparam int CMD_W   = 2;
   localparam int VALUE_W = 8;
   localparam int COUNT_W = 6;

   localparam logic [CMD_W-1:0]   CMD_APPEND = 2'd0;
   localparam logic [CMD_W-1:0]   CMD_POP    = 2'd1;
   localparam logic [CMD_W-1:0]   CMD_REMOVE = 2'd2;
   localparam logic [VALUE_W-1:0] EMPTY_SLOT = 8'hff;

   typedef enum logic [1:0] {
      OP_APPEND,
      OP_POP,
      OP_REMOVE,
      OP_BAD
   } op_type;

   typedef struct packed {
      op_type               op;
      logic [VALUE_W-1:0]   value;
   } queue_entry_type;

   typedef struct packed {
      logic                 valid;
      op_type               op;
      logic [VALUE_W-1:0]   value;
   } queue_head_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SCAN  = 3'b010,
      ST_SHIFT = 3'b100
   } back_state_type;

endpackage

[rtl/olal_front.sv]
// olal_front: takes command words, decodes them and holds them in a two-entry queue
// depends on olal_pkg
module olal_front import olal_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [CMD_W-1:0]     req_command,
   input  logic [VALUE_W-1:0]   req_value,
   output queue_head_type       head,
   input  logic                 head_pop
);

   queue_entry_type q_ff [2];
   logic            wr_ptr_ff, wr_ptr_in;
   logic            rd_ptr_ff, rd_ptr_in;
   logic [1:0]      count_ff, count_in;
   logic            push;
   op_type          op_dec;

   always_comb begin
      unique case (req_command)
         CMD_APPEND: op_dec = OP_APPEND;
         CMD_POP:    op_dec = OP_POP;
         CMD_REMOVE: op_dec = OP_REMOVE;
         default:    op_dec = OP_BAD;
      endcase
   end

   assign busy = (count_ff == 2'd2);
   assign push = start && !busy;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ head_pop;
      count_in  = count_ff;
      if (push && !head_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && head_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= '{op: op_dec, value: req_value};
      end
   end

   assign head.valid = (count_ff != 2'd0);
   assign head.op    = q_ff[rd_ptr_ff].op;
   assign head.value = q_ff[rd_ptr_ff].value;

endmodule

[rtl/olal_back.sv]
// olal_back: list storage and sequencer for append, remove-last and remove-by-value
// depends on olal_pkg; takes decoded words from olal_front
module olal_back import olal_pkg::*; #(
   parameter int LIST_DEPTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  queue_head_type                        head,
   output logic                                  head_pop,
   output logic                                  rsp_valid,
   output logic                                  rsp_failed,
   output logic [COUNT_W-1:0]                    rsp_count,
   output logic [$clog2(LIST_DEPTH+1)-1:0]       list_len
);

   localparam int CW = $clog2(LIST_DEPTH + 1);
   localparam int AW = $clog2(LIST_DEPTH);
   localparam logic [CW-1:0] FULL = CW'(LIST_DEPTH);

   logic [VALUE_W-1:0] mem [LIST_DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;

   back_state_type     state_ff, state_in;
   logic [CW-1:0]      len_ff, len_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic               pend_ff, pend_in;
   logic [CW-1:0]      pend_idx_ff, pend_idx_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_failed_ff, rsp_failed_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [VALUE_W-1:0] wr_data;
   logic [AW-1:0]      rd_addr;
   logic [CW-1:0]      len_dec;
   logic [CW-1:0]      shift_dst;
   logic               hit;

   assign len_dec   = len_ff - 1'b1;
   assign shift_dst = pend_idx_ff - 1'b1;
   assign hit       = pend_ff && (rd_data_ff == value_ff);
   assign rd_addr   = idx_ff[AW-1:0];

   always_comb begin
      state_in      = state_ff;
      len_in        = len_ff;
      idx_in        = idx_ff;
      pend_in       = 1'b0;
      pend_idx_in   = idx_ff;
      value_in      = value_ff;
      rsp_valid_in  = 1'b0;
      rsp_failed_in = 1'b0;
      head_pop      = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = len_ff[AW-1:0];
      wr_data       = head.value;

      unique case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               head_pop     = 1'b1;
               rsp_valid_in = 1'b1;
               case (head.op)
                  OP_APPEND: begin
                     if (len_ff == FULL) begin
                        rsp_failed_in = 1'b1;
                     end else begin
                        wr_en  = 1'b1;
                        len_in = len_ff + 1'b1;
                     end
                  end
                  OP_POP: begin
                     if (len_ff == '0) begin
                        rsp_failed_in = 1'b1;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = len_dec[AW-1:0];
                        wr_data = EMPTY_SLOT;
                        len_in  = len_dec;
                     end
                  end
                  OP_REMOVE: begin
                     if (len_ff == '0) begin
                        rsp_failed_in = 1'b1;
                     end else begin
                        // result comes once the scan ends, or on a match once the shift ends
                        rsp_valid_in = 1'b0;
                        value_in     = head.value;
                        idx_in       = '0;
                        state_in     = ST_SCAN;
                     end
                  end
                  default: begin
                     rsp_failed_in = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // one read issued per cycle, compared in the next cycle
            if (hit) begin
               idx_in   = pend_idx_ff + 1'b1;
               state_in = ST_SHIFT;
            end else if (idx_ff == len_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_failed_in = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               pend_in = 1'b1;
               idx_in  = idx_ff + 1'b1;
            end
         end
         ST_SHIFT: begin
            // entry read from slot k lands in slot k-1 in the next cycle
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = shift_dst[AW-1:0];
               wr_data = rd_data_ff;
            end
            if (idx_ff >= len_ff) begin
               len_in       = len_dec;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               pend_in = 1'b1;
               idx_in  = idx_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_count_in = COUNT_W'(len_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      pend_idx_ff   <= pend_idx_in;
      value_ff      <= value_in;
      rsp_failed_ff <= rsp_failed_in;
      rsp_count_ff  <= rsp_count_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_failed = rsp_failed_ff;
   assign rsp_count  = rsp_count_ff;
   assign list_len   = len_ff;

endmodule

[rtl/ordered_list_append_remove.sv]
// ordered_list_append_remove: ordered byte list with append, remove-last, remove-by-value
// append, remove-last and bad codes finish in the sequencer's idle state; remove-by-value
// scans the list memory port one entry a cycle, on a match then moving each later entry
// down a slot; throughput: one simple command per cycle while no remove-by-value runs;
// results cannot be held off; busy when queue full
// reset clears the count, the queue and the sequencer; slots above the count are never used
module ordered_list_append_remove import olal_pkg::*; #(
   parameter int LIST_DEPTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [CMD_W-1:0]     req_command,
   input  logic [VALUE_W-1:0]   req_value,
   output logic                 rsp_valid,
   output logic                 rsp_failed,
   output logic [COUNT_W-1:0]   rsp_count
);

   localparam int CW = $clog2(LIST_DEPTH + 1);

   queue_head_type head;
   logic           head_pop;
   logic [CW-1:0]  list_len;

   olal_front u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_command (req_command),
      .req_value   (req_value),
      .head        (head),
      .head_pop    (head_pop)
   );

   olal_back #(
      .LIST_DEPTH (LIST_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_pop   (head_pop),
      .rsp_valid  (rsp_valid),
      .rsp_failed (rsp_failed),
      .rsp_count  (rsp_count),
      .list_len   (list_len)
   );

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      list_len <= CW'(LIST_DEPTH))
      else $error("list length above depth");

   a_len_step: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> (list_len == $past(list_len) ||
                         list_len == $past(list_len) + 1'b1 ||
                         list_len == $past(list_len) - 1'b1))
      else $error("list length moved by more than one");

   a_ok_changes_len: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) && rsp_valid && !rsp_failed |-> list_len != $past(list_len))
      else $error("successful word left length unchanged");

   a_fail_keeps_len: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) && rsp_valid && rsp_failed |-> list_len == $past(list_len))
      else $error("failed word changed length");

   a_pop_needs_head: assert property (@(posedge clock) disable iff (reset)
      head_pop |-> head.valid)
      else $error("queue popped while empty");

endmodule
